[src/qsu_pkg.sv]
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and constants for the quoted string unescape decoder.
// ----------------------------------------------------------------------------
package qsu_pkg;

  // Input item: one character or the end marker
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_marker;
  } in_item_t;

  // Output item: a decoded byte or the closing status of a string
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status_valid;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // One result without its last flag
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status_valid;
    logic [1:0] status;
  } res_t;

  // Queue entry: results of one input item (one or two)
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } cmd_t;

  // Queue fill flags seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_BODY   = 3'd1,
    PH_ESC    = 3'd2,
    PH_OCT    = 3'd3,
    PH_CLOSED = 3'd4,
    PH_TRAIL  = 3'd5,
    PH_BAD    = 3'd6
  } phase_t;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_QUOTE = 2'd1;
  localparam logic [1:0] ST_UNCLOSED = 2'd2;
  localparam logic [1:0] ST_TRAILING = 2'd3;

  // Queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

endpackage

[src/qsu_front.sv]
// ----------------------------------------------------------------------------
// qsu_front
// Accepts input items, runs the quote/escape parser and pushes the results
// of each item that yields any as one command into the queue.
// ----------------------------------------------------------------------------
module qsu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  qsu_pkg::in_item_t in_item,
  input  logic             q_full,
  output logic             push,
  output qsu_pkg::cmd_t    cmd
);
  import qsu_pkg::*;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;

  // Map of single-letter escapes; anything else stands for itself
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      CH_N:    v = 8'h0A;
      CH_R:    v = 8'h0D;
      CH_T:    v = 8'h09;
      CH_B:    v = 8'h08;
      CH_F:    v = 8'h0C;
      CH_V:    v = 8'h0B;
      default: v = c;
    endcase
    return v;
  endfunction

  function automatic res_t byte_res(input logic [7:0] b);
    res_t r;
    r = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic res_t stat_res(input logic [1:0] s);
    res_t r;
    r = '0;
    r.status_valid = 1'b1;
    r.status       = s;
    return r;
  endfunction

  phase_t     phase, phase_next;
  logic [7:0] quote_char, quote_char_next;
  logic [8:0] octal_value, octal_value_next;
  logic [1:0] octal_digits, octal_digits_next;

  logic [7:0] c;
  logic       fire;
  logic       is_oct;
  logic       is_quote;
  logic       is_bs;
  logic [8:0] oct_shift;
  logic       emit;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign c        = in_item.in_byte;
  assign is_oct   = (c >= CH_ZERO) && (c <= CH_SEVEN);
  assign is_quote = (c == quote_char);
  assign is_bs    = (c == CH_BSLASH);
  assign oct_shift = {octal_value[5:0], c[2:0]};
  assign push     = fire && emit;

  // Parser step for one item
  always_comb begin
    phase_next        = phase;
    quote_char_next   = quote_char;
    octal_value_next  = octal_value;
    octal_digits_next = octal_digits;
    emit              = 1'b0;
    cmd               = '0;
    if (in_item.end_marker) begin
      emit = 1'b1;
      unique case (phase)
        PH_START:  cmd.r0 = stat_res(ST_NO_QUOTE);
        PH_BODY:   cmd.r0 = stat_res(ST_UNCLOSED);
        PH_ESC:    cmd.r0 = stat_res(ST_UNCLOSED);
        PH_OCT: begin
          cmd.r0  = byte_res(octal_value[7:0]);
          cmd.r1  = stat_res(ST_UNCLOSED);
          cmd.two = 1'b1;
        end
        PH_CLOSED: cmd.r0 = stat_res(ST_OK);
        PH_TRAIL:  cmd.r0 = stat_res(ST_TRAILING);
        default:   cmd.r0 = stat_res(ST_NO_QUOTE);
      endcase
      phase_next        = PH_START;
      quote_char_next   = '0;
      octal_value_next  = '0;
      octal_digits_next = '0;
    end else begin
      unique case (phase)
        PH_START: begin
          if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            quote_char_next = c;
            phase_next      = PH_BODY;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_BODY: begin
          if (is_quote) begin
            phase_next = PH_CLOSED;
          end else if (is_bs) begin
            phase_next = PH_ESC;
          end else begin
            emit   = 1'b1;
            cmd.r0 = byte_res(c);
          end
        end
        PH_ESC: begin
          if (is_oct) begin
            octal_value_next  = {6'd0, c[2:0]};
            octal_digits_next = 2'd1;
            phase_next        = PH_OCT;
          end else begin
            emit       = 1'b1;
            cmd.r0     = byte_res(esc_map(c));
            phase_next = PH_BODY;
          end
        end
        PH_OCT: begin
          if (is_oct) begin
            if (octal_digits == 2'd2) begin
              // third digit closes the escape at once
              emit              = 1'b1;
              cmd.r0            = byte_res(oct_shift[7:0]);
              octal_value_next  = '0;
              octal_digits_next = '0;
              phase_next        = PH_BODY;
            end else begin
              octal_value_next  = oct_shift;
              octal_digits_next = octal_digits + 2'd1;
            end
          end else begin
            // escape ends early: flush the byte, then treat c as body text
            emit              = 1'b1;
            cmd.r0            = byte_res(octal_value[7:0]);
            octal_value_next  = '0;
            octal_digits_next = '0;
            if (is_quote) begin
              phase_next = PH_CLOSED;
            end else if (is_bs) begin
              phase_next = PH_ESC;
            end else begin
              cmd.r1     = byte_res(c);
              cmd.two    = 1'b1;
              phase_next = PH_BODY;
            end
          end
        end
        PH_CLOSED: phase_next = PH_TRAIL;
        PH_TRAIL:  phase_next = PH_TRAIL;
        default:   phase_next = PH_BAD;
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      quote_char   <= '0;
      octal_value  <= '0;
      octal_digits <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      quote_char   <= quote_char_next;
      octal_value  <= octal_value_next;
      octal_digits <= octal_digits_next;
    end
  end

endmodule

[src/qsu_fifo.sv]
// ----------------------------------------------------------------------------
// qsu_fifo
// Short command queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module qsu_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qsu_pkg::cmd_t       wdata,
  input  logic                pop,
  output qsu_pkg::cmd_t       rdata,
  output qsu_pkg::fifo_stat_t stat
);
  import qsu_pkg::*;

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/qsu_back.sv]
// ----------------------------------------------------------------------------
// qsu_back
// Unpacks queued commands into single output items through an output
// register; a second result of a command waits in a hold register.
// ----------------------------------------------------------------------------
module qsu_back (
  input  logic                clk,
  input  logic                rst,
  input  qsu_pkg::cmd_t       cmd,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output qsu_pkg::out_item_t  out_item
);
  import qsu_pkg::*;

  logic  load;
  logic  pend;
  res_t  pend_res;

  assign load = !out_valid || out_ready;
  assign pop  = load && !pend && !q_empty;

  // Hold flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else if (load) begin
      if (pend) begin
        pend      <= 1'b0;
        out_valid <= 1'b1;
      end else if (!q_empty) begin
        pend      <= cmd.two;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        out_item <= {pend_res, 1'b1};
      end else if (!q_empty) begin
        out_item <= {cmd.r0, !cmd.two};
        pend_res <= cmd.r1;
      end
    end
  end

endmodule

[src/quoted_string_unescape_decoder.sv]
// ----------------------------------------------------------------------------
// quoted_string_unescape_decoder
// Decodes a quoted string with backslash escapes, one character per item,
// and reports a closing status at the end marker.
// ----------------------------------------------------------------------------
// Path: the first result of an item is registered in a queue entry and then
// in the output register.
// Throughput: one item per cycle while the queue is not full; an item that
// yields two results holds the single output register for both in turn, and the 4-entry queue absorbs it.
// Reset: synchronous; clears the parser phase, the queue and output valid.
module quoted_string_unescape_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qsu_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output qsu_pkg::out_item_t out_item
);
  import qsu_pkg::*;

  logic       push;
  logic       pop;
  cmd_t       wcmd;
  cmd_t       rcmd;
  fifo_stat_t qstat;

  // Parser
  qsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (qstat.full),
    .push     (push),
    .cmd      (wcmd)
  );

  // Command queue
  qsu_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wcmd),
    .pop   (pop),
    .rdata (rcmd),
    .stat  (qstat)
  );

  // Output stage
  qsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (rcmd),
    .q_empty   (qstat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // A status item carries no byte and always ends its input item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status_valid |-> !out_item.byte_valid && out_item.last)
    else $error("status item with byte or without last");

  // A byte item carries a clear status field
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.status_valid |-> out_item.byte_valid &&
      out_item.status == ST_OK)
    else $error("byte item with status bits set");

  // The queue is never full and empty at once
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty together");

  // No push is issued into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into full queue");
`endif

endmodule

[tb/quoted_string_unescape_decoder_tb.sv]
// ----------------------------------------------------------------------------
// quoted_string_unescape_decoder_tb
// Self-checking bench for the quoted string unescape decoder. A short table
// of directed strings covers escapes, octal edge cases and every status but
// OK, then random strings, mostly well formed, run with bursty input and a
// stalling output. Every result is checked against a local decoder model.
// ----------------------------------------------------------------------------
module quoted_string_unescape_decoder_tb;
  import qsu_pkg::*;

  localparam int N_ITEMS   = 1700;
  localparam int IDLE_MAX  = 2000;
  localparam int DRAIN_CYC = 12;
  localparam int PRINT_MAX = 40;

  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BSL = 8'h5C;

  localparam logic [7:0] ESC_LETTERS [6] = '{"n", "r", "t", "b", "f", "v"};

  // Directed row: one input item, optionally with its single result typed in
  typedef struct packed {
    logic [7:0] ch;
    logic       endm;
    logic       typed;
    out_item_t  want;
  } row_t;

  localparam out_item_t W_NONE  = '0;
  localparam out_item_t W_NOQ   = '{8'h00, 1'b0, 1'b1, ST_NO_QUOTE, 1'b1};
  localparam out_item_t W_TRAIL = '{8'h00, 1'b0, 1'b1, ST_TRAILING, 1'b1};
  localparam out_item_t W_FF    = '{8'hFF, 1'b1, 1'b0, ST_OK, 1'b1};
  localparam out_item_t W_NUL   = '{8'h00, 1'b1, 1'b0, ST_OK, 1'b1};

  localparam int DIR_LEN = 25;
  localparam row_t DIR_TAB [DIR_LEN] = '{
    '{8'h00,  1'b1, 1'b1, W_NOQ},    // empty right after reset
    '{8'hFF,  1'b0, 1'b0, W_NONE},   // bad opening byte
    '{8'h00,  1'b1, 1'b1, W_NOQ},
    '{CH_SQ,  1'b0, 1'b0, W_NONE},   // single quoted
    '{CH_BSL, 1'b0, 1'b0, W_NONE},
    '{"7",    1'b0, 1'b0, W_NONE},
    '{"7",    1'b0, 1'b0, W_NONE},
    '{"7",    1'b0, 1'b1, W_FF},     // octal 777 truncates to 8 bits
    '{CH_BSL, 1'b0, 1'b0, W_NONE},
    '{"r",    1'b0, 1'b0, W_NONE},
    '{CH_BSL, 1'b0, 1'b0, W_NONE},
    '{CH_BSL, 1'b0, 1'b0, W_NONE},   // escaped backslash
    '{CH_BSL, 1'b0, 1'b0, W_NONE},
    '{"0",    1'b0, 1'b0, W_NONE},
    '{CH_DQ,  1'b0, 1'b0, W_NONE},   // ends octal early, two results
    '{CH_SQ,  1'b0, 1'b0, W_NONE},   // closing quote
    '{"q",    1'b0, 1'b0, W_NONE},   // trailing byte
    '{8'h00,  1'b1, 1'b1, W_TRAIL},
    '{CH_DQ,  1'b0, 1'b0, W_NONE},
    '{8'h00,  1'b0, 1'b1, W_NUL},
    '{CH_BSL, 1'b0, 1'b0, W_NONE},
    '{"1",    1'b0, 1'b0, W_NONE},
    '{"2",    1'b0, 1'b0, W_NONE},
    '{8'hFF,  1'b1, 1'b0, W_NONE},   // end inside octal: byte then unclosed
    '{8'hFF,  1'b1, 1'b1, W_NOQ}
  };

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Decoder model state
  phase_t     ph      = PH_START;
  logic [7:0] q_char  = '0;
  logic [8:0] oct_val = '0;
  logic [1:0] oct_cnt = '0;

  out_item_t  step_res [$];
  out_item_t  pending_results [$];
  in_item_t   str_q [$];

  int         err_cnt    = 0;
  int         burst_left = 0;
  int         idle_cyc   = 0;
  logic [31:0] cyc       = '0;
  logic [1:0]  rx_mode   = 2'd0;

  quoted_string_unescape_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mismatch report: one line each, printing capped
  task automatic report(input string what, input out_item_t got, input out_item_t exp);
    err_cnt++;
    if (err_cnt <= PRINT_MAX) begin
      $display("ERROR %0s: got %02h/%0b/%0b/%0d/%0b exp %02h/%0b/%0b/%0d/%0b",
               what, got.out_byte, got.byte_valid, got.status_valid, got.status,
               got.last, exp.out_byte, exp.byte_valid, exp.status_valid,
               exp.status, exp.last);
    end
  endtask

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= "0") && (c <= "7");
  endfunction

  task automatic emit(input logic [7:0] b, input logic bv, input logic sv,
                      input logic [1:0] st);
    out_item_t r;
    r.out_byte     = b;
    r.byte_valid   = bv;
    r.status_valid = sv;
    r.status       = st;
    r.last         = 1'b0;
    step_res = {step_res, r};
  endtask

  // Plain character inside the quotes
  task automatic take_body_char(input logic [7:0] c);
    if (c == q_char) begin
      ph = PH_CLOSED;
    end else if (c == CH_BSL) begin
      ph = PH_ESC;
    end else begin
      ph = PH_BODY;
      emit(c, 1'b1, 1'b0, ST_OK);
    end
  endtask

  // Decode one accepted item, queue its results
  task automatic predict_item(input in_item_t it);
    logic [7:0] c;
    logic [7:0] v;
    logic [1:0] st;
    c = it.in_byte;
    step_res.delete();
    if (it.end_marker) begin
      case (ph) inside
        PH_START:        st = ST_NO_QUOTE;
        PH_BODY, PH_ESC: st = ST_UNCLOSED;
        PH_OCT: begin
          emit(oct_val[7:0], 1'b1, 1'b0, ST_OK);
          st = ST_UNCLOSED;
        end
        PH_CLOSED:       st = ST_OK;
        PH_TRAIL:        st = ST_TRAILING;
        default:         st = ST_NO_QUOTE;
      endcase
      emit(8'h00, 1'b0, 1'b1, st);
      ph      = PH_START;
      q_char  = '0;
      oct_val = '0;
      oct_cnt = '0;
    end else begin
      case (ph) inside
        PH_START: begin
          if (c == CH_DQ || c == CH_SQ) begin
            q_char = c;
            ph     = PH_BODY;
          end else begin
            ph = PH_BAD;
          end
        end
        PH_BODY: take_body_char(c);
        PH_ESC: begin
          if (is_oct(c)) begin
            oct_val = {6'd0, c[2:0]};
            oct_cnt = 2'd1;
            ph      = PH_OCT;
          end else begin
            case (c)
              "n":     v = 8'h0A;
              "r":     v = 8'h0D;
              "t":     v = 8'h09;
              "b":     v = 8'h08;
              "f":     v = 8'h0C;
              "v":     v = 8'h0B;
              default: v = c;
            endcase
            ph = PH_BODY;
            emit(v, 1'b1, 1'b0, ST_OK);
          end
        end
        PH_OCT: begin
          if (is_oct(c)) begin
            oct_val = {oct_val[5:0], c[2:0]};
            oct_cnt = oct_cnt + 2'd1;
            // third digit closes the escape at once
            if (oct_cnt == 2'd3) begin
              emit(oct_val[7:0], 1'b1, 1'b0, ST_OK);
              oct_val = '0;
              oct_cnt = '0;
              ph      = PH_BODY;
            end
          end else begin
            emit(oct_val[7:0], 1'b1, 1'b0, ST_OK);
            oct_val = '0;
            oct_cnt = '0;
            take_body_char(c);
          end
        end
        PH_CLOSED, PH_TRAIL: ph = PH_TRAIL;
        default:             ph = PH_BAD;
      endcase
    end
    if (step_res.size() > 0) begin
      step_res[step_res.size() - 1].last = 1'b1;
    end
    foreach (step_res[i]) pending_results = {pending_results, step_res[i]};
  endtask

  // Send one item in bursts with random gaps, then predict it
  task automatic push_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  // Hold input until every queued result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_char(input logic [7:0] c);
    in_item_t it;
    it.in_byte    = c;
    it.end_marker = 1'b0;
    str_q = {str_q, it};
  endtask

  // Build one random string; returns 1 if it is noise only
  task automatic build_string(output logic noise);
    int         kind;
    int         n;
    int         r;
    logic [7:0] q;
    in_item_t   it;
    str_q.delete();
    noise = 1'b0;
    kind  = $urandom_range(0, 99);
    q     = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
    if (kind < 80) begin
      add_char(q);
      n = $urandom_range(0, 10);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          add_char(8'($urandom_range(0, 255)));
        end else if (r < 6) begin
          add_char(CH_BSL);
          add_char(ESC_LETTERS[3'($urandom_range(0, 5))]);
        end else if (r == 6) begin
          add_char(CH_BSL);
          add_char(8'($urandom_range(0, 255)));
        end else begin
          add_char(CH_BSL);
          repeat ($urandom_range(1, 3)) add_char(8'("0" + $urandom_range(0, 7)));
        end
      end
      r = $urandom_range(0, 19);
      if (r < 15) begin
        add_char(q);
      end else if (r < 17) begin
        add_char(q);
        repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(0, 255)));
      end else if (r == 17) begin
        add_char(CH_BSL);
      end
    end else if (kind < 90) begin
      noise = 1'b1;
      repeat ($urandom_range(0, 8)) add_char(8'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      add_char(q);
      add_char(q);
    end else if (kind < 98) begin
      add_char(q);
    end
    it.in_byte    = 8'($urandom_range(0, 255));
    it.end_marker = 1'b1;
    str_q = {str_q, it};
  endtask

  // Receiver: picks a new random ready mode whenever the low byte of the cycle count is zero
  always @(posedge clk) begin
    cyc <= cyc + 32'd1;
    if (cyc[7:0] == 8'd0) begin
      rx_mode <= 2'($urandom_range(0, 2));
    end
    case (rx_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (cyc[2:0] < 3'd3);
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    out_item_t exp;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_item, W_NONE);
      end else begin
        exp = pending_results.pop_front();
        if (out_item.out_byte !== exp.out_byte)         report("out_byte", out_item, exp);
        if (out_item.byte_valid !== exp.byte_valid)     report("byte_valid", out_item, exp);
        if (out_item.status_valid !== exp.status_valid) report("status_valid", out_item, exp);
        if (out_item.status !== exp.status)             report("status", out_item, exp);
        if (out_item.last !== exp.last)                 report("last", out_item, exp);
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_MAX) begin
      $display("timeout: no progress for %0d cycles", IDLE_MAX);
      $display("quoted_string_unescape_decoder_tb NOT OK");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // Stimulus
  initial begin
    in_item_t it;
    logic     noise;
    logic     held;
    int       sent;
    held = 1'b0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed strings
    for (int i = 0; i < DIR_LEN; i++) begin
      it.in_byte    = DIR_TAB[i].ch;
      it.end_marker = DIR_TAB[i].endm;
      push_item(it);
      if (DIR_TAB[i].typed && (step_res.size() != 1 || step_res[0] != DIR_TAB[i].want)) begin
        report($sformatf("table row %0d", i), step_res.size() > 0 ? step_res[0] : W_NONE,
               DIR_TAB[i].want);
      end
    end
    wait_drained();

    // random strings, with one full drain halfway through
    while (sent < N_ITEMS) begin
      if (!held && sent >= N_ITEMS / 2) begin
        wait_drained();
        held = 1'b1;
      end
      build_string(noise);
      foreach (str_q[i]) push_item(str_q[i]);
      if (!noise) sent += str_q.size();
    end

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("quoted_string_unescape_decoder_tb OK");
    end else begin
      $display("quoted_string_unescape_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule

[quoted_string_unescape_decoder.f]
src/qsu_pkg.sv
src/qsu_front.sv
src/qsu_fifo.sv
src/qsu_back.sv
src/quoted_string_unescape_decoder.sv
tb/quoted_string_unescape_decoder_tb.sv
